/* sv/sf3d_pkg.sv */
// Types and constants shared by the spring force pipeline.
package sf3d_pkg;

    localparam int COORD_W  = 32;
    localparam int MAG_W    = 33;
    localparam int SQ_W     = 66;
    localparam int SUM_W    = 68;
    localparam int ROOT_W   = 35;
    localparam int SQRT_LAT = ROOT_W;
    localparam int QUO_W    = 32;
    localparam int DIV_LAT  = QUO_W + 1;
    localparam int CFG_W    = 31;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx REG_STIFFNESS = 1'b0;
    localparam t_cfg_idx REG_REST      = 1'b1;

    typedef struct packed {
        logic signed [31:0] near_end_x;
        logic signed [31:0] near_end_y;
        logic signed [31:0] near_end_z;
        logic signed [31:0] far_end_x;
        logic signed [31:0] far_end_y;
        logic signed [31:0] far_end_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] apply_x;
        logic signed [31:0] apply_y;
        logic signed [31:0] apply_z;
        logic               zero_length;
        logic               saturated;
    } t_out;

    // Data that rides alongside the length computation
    typedef struct packed {
        logic signed [31:0] apply_x;
        logic signed [31:0] apply_y;
        logic signed [31:0] apply_z;
        logic [32:0]        mag_x;
        logic [32:0]        mag_y;
        logic [32:0]        mag_z;
        logic               pos_x;
        logic               pos_y;
        logic               pos_z;
    } t_side;

    // Data that rides alongside the divider
    typedef struct packed {
        logic signed [31:0] apply_x;
        logic signed [31:0] apply_y;
        logic signed [31:0] apply_z;
        logic [2:0]         pos;
        logic               zero;
    } t_tail;

endpackage

/* sv/spring_force_3d_core.sv */
// Top level: pipelined Hooke spring force between two points in 3D.
//
// Usage: drive the six end coordinates on i_data and pulse i_start; o_busy is
// always low, so a transaction is taken in every cycle that i_start is high.
// Each transaction yields one result on o_result, marked by o_valid for a
// single cycle, with a throughput of one transaction per cycle. The
// pipeline is made up of the square root (35 stages, one root bit each),
// the three divider lanes (33 stages: an overflow check, then one quotient
// bit per stage), plus eight stages of difference, squaring, sum, stretch,
// multiply and output saturation.
// Stiffness and rest length are written through i_cfg_we/i_cfg_idx/
// i_cfg_data while no transaction is in flight; both reset to 1.0.
// Reset is synchronous, active low, and empties the pipeline; results in
// flight are dropped. Coincident ends give zero force with zero_length set.
// The receiver takes every result in its cycle: there is no back-pressure.
module spring_force_3d_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  sf3d_pkg::t_in                   i_data,
    output logic                            o_valid,
    output sf3d_pkg::t_out                  o_result,
    input  logic                            i_cfg_we,
    input  sf3d_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [sf3d_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int MAG_W = sf3d_pkg::MAG_W;
    localparam int RW    = sf3d_pkg::ROOT_W;
    localparam int CW    = sf3d_pkg::CFG_W;
    localparam int PW    = CW + RW;
    localparam int MW    = PW - FRAC_BITS;
    localparam int ML    = MW / 2;
    localparam int MH    = MW - ML;
    localparam int NW    = MAG_W + MW;
    localparam int LAT   = 3 + sf3d_pkg::SQRT_LAT + 4 + sf3d_pkg::DIV_LAT + 1;

    // Configuration registers
    logic [CW-1:0] r_stiff;
    logic [CW-1:0] r_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= CW'(65536);
            r_rest  <= CW'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sf3d_pkg::REG_STIFFNESS: r_stiff <= i_cfg_data;
                sf3d_pkg::REG_REST:      r_rest  <= i_cfg_data;
                default:                 r_rest  <= r_rest;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic w_accept;
    assign w_accept = i_start && !o_busy;

    // Stage A: differences and magnitudes
    logic signed [MAG_W-1:0] w_d [0:2];
    sf3d_pkg::t_side         n_a_side;

    assign w_d[0] = MAG_W'(i_data.near_end_x) - MAG_W'(i_data.far_end_x);
    assign w_d[1] = MAG_W'(i_data.near_end_y) - MAG_W'(i_data.far_end_y);
    assign w_d[2] = MAG_W'(i_data.near_end_z) - MAG_W'(i_data.far_end_z);

    always_comb begin
        n_a_side.apply_x = i_data.near_end_x;
        n_a_side.apply_y = i_data.near_end_y;
        n_a_side.apply_z = i_data.near_end_z;
        n_a_side.mag_x   = w_d[0][MAG_W-1] ? -w_d[0] : w_d[0];
        n_a_side.mag_y   = w_d[1][MAG_W-1] ? -w_d[1] : w_d[1];
        n_a_side.mag_z   = w_d[2][MAG_W-1] ? -w_d[2] : w_d[2];
        n_a_side.pos_x   = !w_d[0][MAG_W-1] && (w_d[0] != '0);
        n_a_side.pos_y   = !w_d[1][MAG_W-1] && (w_d[1] != '0);
        n_a_side.pos_z   = !w_d[2][MAG_W-1] && (w_d[2] != '0);
    end

    logic            r_a_vld;
    sf3d_pkg::t_side r_a_side;

    // Stage B: squares
    logic                        r_b_vld;
    logic [sf3d_pkg::SQ_W-1:0]   r_b_sq [0:2];
    sf3d_pkg::t_side             r_b_side;

    // Stage C: sum of squares
    logic                        r_c_vld;
    logic [sf3d_pkg::SUM_W-1:0]  r_c_sum;
    sf3d_pkg::t_side             r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_side  <= n_a_side;
        r_b_sq[0] <= sf3d_pkg::SQ_W'(r_a_side.mag_x) * sf3d_pkg::SQ_W'(r_a_side.mag_x);
        r_b_sq[1] <= sf3d_pkg::SQ_W'(r_a_side.mag_y) * sf3d_pkg::SQ_W'(r_a_side.mag_y);
        r_b_sq[2] <= sf3d_pkg::SQ_W'(r_a_side.mag_z) * sf3d_pkg::SQ_W'(r_a_side.mag_z);
        r_b_side  <= r_a_side;
        r_c_sum   <= sf3d_pkg::SUM_W'(r_b_sq[0]) + sf3d_pkg::SUM_W'(r_b_sq[1])
                   + sf3d_pkg::SUM_W'(r_b_sq[2]);
        r_c_side  <= r_b_side;
    end

    // Length
    logic            w_s_vld;
    logic [RW-1:0]   w_s_root;
    sf3d_pkg::t_side w_s_side;

    sf3d_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_vld),
        .i_sum   (r_c_sum),
        .i_side  (r_c_side),
        .o_valid (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    // Stage D: stretch, Stage E: magnitude
    logic            r_d_vld;
    logic [RW-1:0]   r_d_len;
    logic [RW-1:0]   r_d_diff;
    logic            r_d_zero;
    sf3d_pkg::t_side r_d_side;

    logic            r_e_vld;
    logic [MW-1:0]   r_e_m;
    logic [RW-1:0]   r_e_len;
    logic            r_e_zero;
    sf3d_pkg::t_side r_e_side;

    logic [PW-1:0]   w_prod;
    assign w_prod = PW'(r_stiff) * PW'(r_d_diff);

    // Stage F: split partial products, Stage G: numerators
    logic                  r_f_vld;
    logic [MAG_W+ML-1:0]   r_f_plo [0:2];
    logic [MAG_W+MH-1:0]   r_f_phi [0:2];
    logic [RW-1:0]         r_f_len;
    logic                  r_f_zero;
    sf3d_pkg::t_side       r_f_side;

    logic                  r_g_vld;
    logic [NW-1:0]         r_g_num [0:2];
    logic [RW-1:0]         r_g_len;
    sf3d_pkg::t_tail       r_g_tail;

    logic [MAG_W-1:0] w_e_mag [0:2];
    assign w_e_mag[0] = r_e_side.mag_x;
    assign w_e_mag[1] = r_e_side.mag_y;
    assign w_e_mag[2] = r_e_side.mag_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            r_d_vld <= w_s_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_len  <= w_s_root;
        r_d_diff <= (w_s_root >= RW'(r_rest)) ? (w_s_root - RW'(r_rest))
                                              : (RW'(r_rest) - w_s_root);
        r_d_zero <= (w_s_root == '0);
        r_d_side <= w_s_side;

        r_e_m    <= w_prod[PW-1:FRAC_BITS];
        r_e_len  <= r_d_len;
        r_e_zero <= r_d_zero;
        r_e_side <= r_d_side;

        for (int i = 0; i < 3; i++) begin
            r_f_plo[i] <= (MAG_W+ML)'(w_e_mag[i]) * (MAG_W+ML)'(r_e_m[ML-1:0]);
            r_f_phi[i] <= (MAG_W+MH)'(w_e_mag[i]) * (MAG_W+MH)'(r_e_m[MW-1:ML]);
        end
        r_f_len  <= r_e_len;
        r_f_zero <= r_e_zero;
        r_f_side <= r_e_side;

        for (int i = 0; i < 3; i++) begin
            r_g_num[i] <= NW'(r_f_plo[i]) + (NW'(r_f_phi[i]) << ML);
        end
        r_g_len          <= r_f_len;
        r_g_tail.apply_x <= r_f_side.apply_x;
        r_g_tail.apply_y <= r_f_side.apply_y;
        r_g_tail.apply_z <= r_f_side.apply_z;
        r_g_tail.pos     <= {r_f_side.pos_z, r_f_side.pos_y, r_f_side.pos_x};
        r_g_tail.zero    <= r_f_zero;
    end

    // Divider lanes
    logic [2:0]                  w_q_vld;
    logic [sf3d_pkg::QUO_W-1:0]  w_q_quo [0:2];
    logic [2:0]                  w_q_over;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        sf3d_div #(
            .NUM_W (NW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_g_vld),
            .i_num   (r_g_num[i]),
            .i_den   (r_g_len),
            .o_valid (w_q_vld[i]),
            .o_quo   (w_q_quo[i]),
            .o_over  (w_q_over[i])
        );
    end

    // Hold the side data level with the divider
    sf3d_pkg::t_tail r_tail [0:sf3d_pkg::DIV_LAT-1];

    for (genvar k = 0; k < sf3d_pkg::DIV_LAT; k++) begin : g_tail
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_tail[k] <= r_g_tail;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    // Stage H: sign, saturate and register the result
    sf3d_pkg::t_tail   w_t;
    logic signed [31:0] n_f [0:2];
    logic [2:0]         n_sat;
    sf3d_pkg::t_out     n_out;

    assign w_t = r_tail[sf3d_pkg::DIV_LAT-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f[i]   = '0;
            n_sat[i] = 1'b0;
            if (!w_t.zero) begin
                if (w_t.pos[i]) begin
                    if (w_q_over[i] || (w_q_quo[i] > 32'h8000_0000)) begin
                        n_f[i]   = 32'sh8000_0000;
                        n_sat[i] = 1'b1;
                    end else begin
                        n_f[i] = -$signed(w_q_quo[i]);
                    end
                end else begin
                    if (w_q_over[i] || w_q_quo[i][31]) begin
                        n_f[i]   = 32'sh7fff_ffff;
                        n_sat[i] = 1'b1;
                    end else begin
                        n_f[i] = $signed(w_q_quo[i]);
                    end
                end
            end
        end
        n_out.force_x     = n_f[0];
        n_out.force_y     = n_f[1];
        n_out.force_z     = n_f[2];
        n_out.apply_x     = w_t.apply_x;
        n_out.apply_y     = w_t.apply_y;
        n_out.apply_z     = w_t.apply_z;
        n_out.zero_length = w_t.zero;
        n_out.saturated   = |n_sat;
    end

    logic           r_out_vld;
    sf3d_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_q_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // Checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_valid)
        else $error("result missing after pipeline latency");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_vld[0] == w_q_vld[1]) && (w_q_vld[0] == w_q_vld[2]))
        else $error("divider lanes out of step");

    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_length) |->
        (o_result.force_x == 0 && o_result.force_y == 0 &&
         o_result.force_z == 0 && !o_result.saturated))
        else $error("nonzero force for coincident ends");

    a_apply_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT (o_result.apply_x == $past(i_data.near_end_x, LAT)))
        else $error("application point does not match body end");

endmodule

/* sv/sf3d_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module sf3d_isqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [sf3d_pkg::SUM_W-1:0]       i_sum,
    input  sf3d_pkg::t_side                  i_side,
    output logic                             o_valid,
    output logic [sf3d_pkg::ROOT_W-1:0]      o_root,
    output sf3d_pkg::t_side                  o_side
);

    localparam int N  = sf3d_pkg::SQRT_LAT;
    localparam int RW = sf3d_pkg::ROOT_W;
    localparam int SW = sf3d_pkg::SUM_W;
    localparam int TW = 2 * RW;

    logic [N-1:0]    r_vld;
    logic [SW-1:0]   r_rem  [0:N-1];
    logic [RW-1:0]   r_root [0:N-1];
    sf3d_pkg::t_side r_side [0:N-1];

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam int B = N - 1 - j;
        logic            w_vld;
        logic [SW-1:0]   w_rem;
        logic [RW-1:0]   w_root;
        sf3d_pkg::t_side w_side;
        logic [TW-1:0]   w_trial;
        logic            w_take;

        if (j == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_rem  = i_sum;
            assign w_root = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[j-1];
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
            assign w_side = r_side[j-1];
        end

        // (2r + 2^b) * 2^b, compared against the running S - r^2
        assign w_trial = (TW'(w_root) << (B + 1)) | (TW'(1) << (2 * B));
        assign w_take  = TW'(w_rem) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j]  <= w_take ? (w_rem - w_trial[SW-1:0]) : w_rem;
            r_root[j] <= w_take ? (w_root | (RW'(1) << B)) : w_root;
            r_side[j] <= w_side;
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_root  = r_root[N-1];
    assign o_side  = r_side[N-1];

endmodule

/* sv/sf3d_div.sv */
// Pipelined restoring divider with a 32-bit quotient and overflow flag.
module sf3d_div #(
    parameter int NUM_W = 83
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [sf3d_pkg::ROOT_W-1:0]   i_den,
    output logic                          o_valid,
    output logic [sf3d_pkg::QUO_W-1:0]    o_quo,
    output logic                          o_over
);

    localparam int QW = sf3d_pkg::QUO_W;
    localparam int DW = sf3d_pkg::ROOT_W;
    localparam int HW = NUM_W - QW;

    // Front stage: quotient of 2^32 or more is overflow
    logic          r_f_vld;
    logic          r_f_over;
    logic [DW-1:0] r_f_rem;
    logic [QW-1:0] r_f_low;
    logic [DW-1:0] r_f_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_over <= i_num[NUM_W-1:QW] >= HW'(i_den);
        r_f_rem  <= i_num[QW+DW-1:QW];
        r_f_low  <= i_num[QW-1:0];
        r_f_den  <= i_den;
    end

    logic [QW-1:0] r_vld;
    logic [DW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_low  [0:QW-1];
    logic [QW-1:0] r_quo  [0:QW-1];
    logic [DW-1:0] r_den  [0:QW-1];
    logic          r_over [0:QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int B = QW - 1 - i;
        logic          w_vld;
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_low;
        logic [QW-1:0] w_quo;
        logic [DW-1:0] w_den;
        logic          w_over;
        logic [DW:0]   w_try;
        logic [DW:0]   w_sub;
        logic          w_ge;
        logic [QW-1:0] n_quo;

        if (i == 0) begin : g_first
            assign w_vld  = r_f_vld;
            assign w_rem  = r_f_rem;
            assign w_low  = r_f_low;
            assign w_quo  = '0;
            assign w_den  = r_f_den;
            assign w_over = r_f_over;
        end else begin : g_next
            assign w_vld  = r_vld[i-1];
            assign w_rem  = r_rem[i-1];
            assign w_low  = r_low[i-1];
            assign w_quo  = r_quo[i-1];
            assign w_den  = r_den[i-1];
            assign w_over = r_over[i-1];
        end

        assign w_try = {w_rem, w_low[B]};
        assign w_ge  = w_try >= {1'b0, w_den};
        assign w_sub = w_try - {1'b0, w_den};

        always_comb begin
            n_quo    = w_quo;
            n_quo[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[i]  <= w_ge ? w_sub[DW-1:0] : w_try[DW-1:0];
            r_low[i]  <= w_low;
            r_quo[i]  <= n_quo;
            r_den[i]  <= w_den;
            r_over[i] <= w_over;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_over  = r_over[QW-1];

endmodule
